/* rtl/mcbd_pkg.sv */
package mcbd_pkg;

  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_BAD   = 3'd1,
    OP_UTF8_2 = 3'd2,
    OP_UTF8_3 = 3'd3,
    OP_U16BE = 3'd4,
    OP_U16LE = 3'd5,
    OP_DBL   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    MODE_UTF8    = 2'd0,
    MODE_UTF16BE = 2'd1,
    MODE_UTF16LE = 2'd2,
    MODE_DBL     = 2'd3
  } mode_e;

  typedef enum logic {
    REG_MODE   = 1'b0,
    REG_STRIDE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [1:0]  ModeReset   = 2'd0;
  localparam logic [7:0]  StrideReset = 8'd157;
  localparam logic [15:0] BadValue    = 16'hFFFE;
  localparam logic [7:0]  AsciiLimit  = 8'h80;
  localparam logic [7:0]  LeadALo     = 8'hA1;
  localparam logic [7:0]  LeadAHi     = 8'hC6;
  localparam logic [7:0]  LeadBLo     = 8'hC9;
  localparam logic [7:0]  LeadBHi     = 8'hF9;
  localparam logic [7:0]  RowBOffset  = 8'hA3;
  localparam logic [7:0]  TrailALo    = 8'h40;
  localparam logic [7:0]  TrailAHi    = 8'h7E;
  localparam logic [7:0]  TrailBLo    = 8'hA1;
  localparam logic [7:0]  TrailBHi    = 8'hFE;
  localparam logic [7:0]  TrailBOffset = 8'h62;

endpackage

/* rtl/mcbd_in_if.sv */
interface mcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/mcbd_out_if.sv */
interface mcbd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        kind;
  logic [1:0]  length;

  modport source (output valid, output value, output kind, output length, input ready);
  modport sink   (input valid, input value, input kind, input length, output ready);
endinterface

/* rtl/mcbd_front.sv */
module mcbd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            mode_i,
  input  logic                  mode_wr_i,
  mcbd_in_if.sink               in_s,
  input  mcbd_pkg::q_status_t   q_status_i,
  output logic                  push_o,
  output mcbd_pkg::entry_t      entry_o
);

  logic [1:0] held_q, held_d;
  logic [1:0] need_q, need_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       start;
  logic       accept;
  logic       is_dbl_lead;
  logic [7:0] b;

  assign in_s.ready = !q_status_i.full;
  assign accept     = in_s.valid && in_s.ready;
  assign b          = in_s.in_byte;
  assign start      = (held_q == 2'd0) || (held_q >= need_q);
  assign is_dbl_lead = ((b >= mcbd_pkg::LeadALo) && (b <= mcbd_pkg::LeadAHi)) ||
                       ((b >= mcbd_pkg::LeadBLo) && (b <= mcbd_pkg::LeadBHi));

  always_comb begin
    held_d   = held_q;
    need_d   = need_q;
    first_d  = first_q;
    second_d = second_q;
    push_o   = 1'b0;
    entry_o.op = mcbd_pkg::OP_PASS;
    entry_o.b0 = start ? b : first_q;
    entry_o.b1 = second_q;
    entry_o.b2 = b;
    if (accept) begin
      if (start) begin
        first_d = b;
        held_d  = 2'd1;
        need_d  = 2'd2;
        unique case (mcbd_pkg::mode_e'(mode_i))
          mcbd_pkg::MODE_UTF8: begin
            if (b < mcbd_pkg::AsciiLimit) begin
              push_o = 1'b1;
              entry_o.op = mcbd_pkg::OP_PASS;
            end else if (b[5]) begin
              need_d = 2'd3;
            end
          end
          mcbd_pkg::MODE_DBL: begin
            if (b < mcbd_pkg::AsciiLimit) begin
              push_o = 1'b1;
              entry_o.op = mcbd_pkg::OP_PASS;
            end else if (!is_dbl_lead) begin
              push_o = 1'b1;
              entry_o.op = mcbd_pkg::OP_BAD;
            end
          end
          default: ;
        endcase
        if (push_o) begin
          held_d = 2'd0;
          need_d = 2'd0;
        end
      end else if (held_q == 2'd1 && need_q == 2'd3) begin
        second_d = b;
        held_d   = 2'd2;
      end else begin
        push_o = 1'b1;
        held_d = 2'd0;
        need_d = 2'd0;
        if (held_q == 2'd2) begin
          entry_o.op = mcbd_pkg::OP_UTF8_3;
        end else begin
          unique case (mcbd_pkg::mode_e'(mode_i))
            mcbd_pkg::MODE_UTF8:    entry_o.op = mcbd_pkg::OP_UTF8_2;
            mcbd_pkg::MODE_UTF16BE: entry_o.op = mcbd_pkg::OP_U16BE;
            mcbd_pkg::MODE_UTF16LE: entry_o.op = mcbd_pkg::OP_U16LE;
            default:                entry_o.op = mcbd_pkg::OP_DBL;
          endcase
        end
      end
    end
    if (mode_wr_i) begin
      held_d = 2'd0;
      need_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 2'd0;
      need_q   <= 2'd0;
      first_q  <= 8'd0;
      second_q <= 8'd0;
    end else begin
      held_q   <= held_d;
      need_q   <= need_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

/* rtl/mcbd_queue.sv */
module mcbd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mcbd_pkg::entry_t    push_data_i,
  input  logic                pop_i,
  output mcbd_pkg::q_status_t status_o,
  output mcbd_pkg::entry_t    head_o
);

  mcbd_pkg::entry_t mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/mcbd_back.sv */
module mcbd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          stride_i,
  input  mcbd_pkg::q_status_t q_status_i,
  input  mcbd_pkg::entry_t    head_i,
  output logic                pop_o,
  mcbd_out_if.source          out_s
);

  logic        valid_q;
  logic [15:0] value_q, value_d;
  logic        kind_q, kind_d;
  logic [1:0]  len_q, len_d;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [15:0] index;

  assign pop_o = !q_status_i.empty && (!valid_q || out_s.ready);

  always_comb begin
    row = (head_i.b0 <= mcbd_pkg::LeadAHi) ? head_i.b0 - mcbd_pkg::LeadALo
                                           : head_i.b0 - mcbd_pkg::RowBOffset;
    if (head_i.b2 >= mcbd_pkg::TrailALo && head_i.b2 <= mcbd_pkg::TrailAHi) begin
      col = head_i.b2 - mcbd_pkg::TrailALo;
    end else if (head_i.b2 >= mcbd_pkg::TrailBLo && head_i.b2 <= mcbd_pkg::TrailBHi) begin
      col = head_i.b2 - mcbd_pkg::TrailBOffset;
    end else begin
      col = 8'd0;
    end
    index = {8'd0, row} * {8'd0, stride_i} + {8'd0, col};
  end

  always_comb begin
    kind_d = 1'b0;
    len_d  = 2'd2;
    unique case (head_i.op)
      mcbd_pkg::OP_PASS: begin
        value_d = {8'd0, head_i.b2};
        len_d   = 2'd1;
      end
      mcbd_pkg::OP_BAD: begin
        value_d = mcbd_pkg::BadValue;
        len_d   = 2'd1;
      end
      mcbd_pkg::OP_UTF8_2:
        value_d = {5'd0, head_i.b0[4:2], head_i.b0[1:0], head_i.b2[5:0]};
      mcbd_pkg::OP_UTF8_3: begin
        value_d = {head_i.b0[3:0], head_i.b1[5:2], head_i.b1[1:0], head_i.b2[5:0]};
        len_d   = 2'd3;
      end
      mcbd_pkg::OP_U16BE: value_d = {head_i.b0, head_i.b2};
      mcbd_pkg::OP_U16LE: value_d = {head_i.b2, head_i.b0};
      mcbd_pkg::OP_DBL: begin
        value_d = index;
        kind_d  = 1'b1;
      end
      default: value_d = mcbd_pkg::BadValue;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_s.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q <= value_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
    end
  end

  assign out_s.valid  = valid_q;
  assign out_s.value  = value_q;
  assign out_s.kind   = kind_q;
  assign out_s.length = len_q;

endmodule

/* rtl/multi_charset_byte_decoder.sv */
// Byte-stream decoder for UTF-8 (unvalidated), UTF-16BE/LE (no surrogates) and
// Big5 double-byte table indexes, selected by the mode register.
// One byte is accepted per cycle while the queue is not full. A front stage
// tracks the partial sequence and queues completed sequences in a two-entry
// queue; the back stage forms the value (one 8x8 multiply-add for table
// indexes) into the output register.
// Write config only while idle; a mode write drops any partial sequence.
module multi_charset_byte_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  mcbd_in_if.sink    in_i,
  mcbd_out_if.source out_o
);

  logic [1:0]          mode_q;
  logic [7:0]          stride_q;
  logic                mode_wr;
  logic                push;
  logic                pop;
  mcbd_pkg::entry_t    push_entry;
  mcbd_pkg::entry_t    head;
  mcbd_pkg::q_status_t q_status;

  assign mode_wr = cfg_we_i && (mcbd_pkg::reg_idx_e'(cfg_idx_i) == mcbd_pkg::REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mcbd_pkg::ModeReset;
      stride_q <= mcbd_pkg::StrideReset;
    end else if (cfg_we_i) begin
      unique case (mcbd_pkg::reg_idx_e'(cfg_idx_i))
        mcbd_pkg::REG_MODE:   mode_q   <= cfg_data_i[1:0];
        mcbd_pkg::REG_STRIDE: stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .mode_wr_i  (mode_wr),
    .in_s       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  mcbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .status_o    (q_status),
    .head_o      (head)
  );

  mcbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stride_i   (stride_q),
    .q_status_i (q_status),
    .head_i     (head),
    .pop_o      (pop),
    .out_s      (out_o)
  );

endmodule
